/* rtl/core/arpc_pkg.sv */
// ARP cache package: field widths, operation codes and the table entry layout.
// No dependencies; used by the interfaces, the cache module and the testbench.
package arpc_pkg;

	localparam int FUNC_W    = 2;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int STAMP_W   = 32;
	localparam int SLOT_W    = 4;
	localparam int TIMEOUT_W = 8;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd15;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_TICK   = 2'd2
	} arpc_func_t;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} arpc_entry_t;

endpackage

/* rtl/core/arpc_if.sv */
// ARP cache channel interfaces: request word (func, ip, mac) and response word.
// Depends on arpc_pkg for field widths.
interface arpc_in_if import arpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IP_W-1:0]   ip_addr;
	logic [MAC_W-1:0]  mac_addr;

	modport source (output valid, func, ip_addr, mac_addr, input ready);
	modport sink   (input valid, func, ip_addr, mac_addr, output ready);
endinterface

interface arpc_out_if import arpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [MAC_W-1:0]  mac_out;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, hit, mac_out, slot, input ready);
	modport sink   (input valid, hit, mac_out, slot, output ready);
endinterface

/* rtl/core/arpc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* rtl/core/arp_cache_table_with_aging.sv */
// ARP cache with aging: IPv4 -> MAC table scanned one entry per cycle.
// A lookup scans until its first hit or the last entry, a tick scans every entry, an insert
// stops at the first free slot or at the last one, and an unused code goes straight to the
// response. One word at a time: req.ready is high only in S_IDLE.
// Reset clears valid bits, the seconds counter and sets the timeout to 15 at once.
// Depends on arpc_pkg, arpc_if, arpc_ram.
module arp_cache_table_with_aging import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	arpc_in_if.sink              req,
	arpc_out_if.source           rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t                   state_q;
	arpc_func_t               op_q;
	logic [IP_W-1:0]          ip_q;
	logic [MAC_W-1:0]         mac_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [STAMP_W-1:0]       seconds_q;
	logic [IDX_W-1:0]         sec_mod_q;
	logic [TIMEOUT_W-1:0]     timeout_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     issue_q;
	logic                     chk_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     res_hit_q;
	logic [MAC_W-1:0]         res_mac_q;
	logic [SLOT_W-1:0]        res_slot_q;
	logic                     rsp_valid_q;
	logic                     rsp_hit_q;
	logic [MAC_W-1:0]         rsp_mac_q;
	logic [SLOT_W-1:0]        rsp_slot_q;

	logic                     ram_re;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	arpc_entry_t              ram_wdata;
	arpc_entry_t              ram_rdata;
	logic [STAMP_W-1:0]       age;
	logic                     expired;
	logic                     lk_hit;
	logic                     ins_free;
	logic [IDX_W-1:0]         ins_pick;
	logic                     scan_end;

	arpc_ram #(
		.WIDTH ($bits(arpc_entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// age unit for the tick scan: one subtract and compare against the timeout
	assign age      = seconds_q - ram_rdata.stamp;
	assign expired  = age > STAMP_W'(timeout_q);
	assign lk_hit   = chk_s1 && valid_q[idx_s1] && (ram_rdata.ip == ip_q);
	assign ins_free = !valid_q[idx_q];
	assign ins_pick = ins_free ? idx_q : sec_mod_q;
	assign scan_end = chk_s1 && (idx_s1 == LAST);

	always_comb begin
		ram_re    = (state_q == S_SCAN) && issue_q && (op_q != FUNC_INSERT);
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = '0;
		if (state_q == S_SCAN) begin
			case (op_q)
				FUNC_LOOKUP: begin
					if (lk_hit) begin
						ram_we          = 1'b1;
						ram_waddr       = idx_s1;
						ram_wdata.ip    = ram_rdata.ip;
						ram_wdata.mac   = ram_rdata.mac;
						ram_wdata.stamp = seconds_q;
					end
				end
				FUNC_INSERT: begin
					if (ins_free || (idx_q == LAST)) begin
						ram_we          = 1'b1;
						ram_waddr       = ins_pick;
						ram_wdata.ip    = ip_q;
						ram_wdata.mac   = mac_q;
						ram_wdata.stamp = seconds_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.hit     = rsp_hit_q;
	assign rsp.mac_out = rsp_mac_q;
	assign rsp.slot    = rsp_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= FUNC_LOOKUP;
			ip_q        <= '0;
			mac_q       <= '0;
			valid_q     <= '0;
			seconds_q   <= '0;
			sec_mod_q   <= '0;
			timeout_q   <= TIMEOUT_RST;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			chk_s1      <= 1'b0;
			idx_s1      <= '0;
			res_hit_q   <= 1'b0;
			res_mac_q   <= '0;
			res_slot_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_mac_q   <= '0;
			rsp_slot_q  <= '0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if ((state_q == S_FIN) && (!rsp_valid_q || rsp.ready))
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= arpc_func_t'(req.func);
						ip_q       <= req.ip_addr;
						mac_q      <= req.mac_addr;
						idx_q      <= '0;
						issue_q    <= 1'b1;
						chk_s1     <= 1'b0;
						res_hit_q  <= 1'b0;
						res_mac_q  <= '0;
						res_slot_q <= '0;
						if (req.func == FUNC_TICK) begin
							seconds_q <= seconds_q + 1'b1;
							if ((seconds_q == '1) || (sec_mod_q == LAST))
								sec_mod_q <= '0;
							else
								sec_mod_q <= sec_mod_q + 1'b1;
						end
						if (req.func == FUNC_LOOKUP || req.func == FUNC_INSERT ||
						    req.func == FUNC_TICK)
							state_q <= S_SCAN;
						else
							state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (issue_q && (op_q != FUNC_INSERT)) begin
						chk_s1 <= 1'b1;
						idx_s1 <= idx_q;
						if (idx_q == LAST)
							issue_q <= 1'b0;
						else
							idx_q <= idx_q + 1'b1;
					end else begin
						chk_s1 <= 1'b0;
					end
					case (op_q)
						FUNC_LOOKUP: begin
							if (lk_hit) begin
								res_hit_q  <= 1'b1;
								res_mac_q  <= ram_rdata.mac;
								res_slot_q <= SLOT_W'(idx_s1);
								state_q    <= S_FIN;
							end else if (scan_end) begin
								state_q <= S_FIN;
							end
						end
						FUNC_INSERT: begin
							if (ram_we) begin
								valid_q[ins_pick] <= 1'b1;
								res_slot_q        <= SLOT_W'(ins_pick);
								state_q           <= S_FIN;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						FUNC_TICK: begin
							if (chk_s1 && valid_q[idx_s1] && expired)
								valid_q[idx_s1] <= 1'b0;
							if (scan_end)
								state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_hit_q   <= res_hit_q;
						rsp_mac_q   <= res_mac_q;
						rsp_slot_q  <= res_slot_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_one_valid_change: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q ^ $past(valid_q)) <= 1)
		else $error("more than one valid bit changed in a cycle");

	a_seconds_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(seconds_q != $past(seconds_q)) |->
		$past(req.valid && req.ready && (req.func == FUNC_TICK)))
		else $error("seconds counter moved without a tick");

	a_sec_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_mod_q <= LAST)
		else $error("seconds modulo counter out of range");

	a_refresh_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (op_q == FUNC_LOOKUP)) |-> valid_q[ram_waddr])
		else $error("stamp refresh on an invalid entry");
`endif

endmodule

/* verif/tb_arp_cache_table_with_aging.sv */
// Self-checking testbench for arp_cache_table_with_aging: directed, then random lookup, insert, tick
// and unused-code traffic, with timeout changes between phases, is checked against an in-bench table model.
// Depends on arpc_pkg, arpc_in_if, arpc_out_if and the cache RTL.
module tb_arp_cache_table_with_aging;
	import arpc_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int TX_MAX_GAP     = 14;
	localparam int RX_MAX_STALL   = 14;
	localparam int SETTLE_CYCLES  = ENTRIES + 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_WORDS   = 1750;
	localparam int POOL_MAX       = 24;
	localparam int REPORT_MAX     = 10;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic              hit;
		logic [MAC_W-1:0]  mac;
		logic [SLOT_W-1:0] slot;
	} arp_reply_t;

	class arp_table_scoreboard;
		bit                   ent_valid [ENTRIES];
		logic [IP_W-1:0]      ent_ip    [ENTRIES];
		logic [MAC_W-1:0]     ent_mac   [ENTRIES];
		logic [STAMP_W-1:0]   ent_stamp [ENTRIES];
		logic [STAMP_W-1:0]   now_sec;
		logic [TIMEOUT_W-1:0] max_age;
		arp_reply_t           replies[$];
		int mismatches, n_checked;
		int n_lookup, n_hit, n_insert, n_evict, n_tick, n_expired, n_unused;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				ent_valid[i] = 1'b0;
				ent_ip[i]    = '0;
				ent_mac[i]   = '0;
				ent_stamp[i] = '0;
			end
			now_sec = '0;
			max_age = TIMEOUT_RST;
		endfunction

		function void note_request(logic [FUNC_W-1:0] func, logic [IP_W-1:0] ip,
				logic [MAC_W-1:0] mac);
			arp_reply_t         r;
			int                 pick;
			logic [STAMP_W-1:0] age;
			r = '0;
			pick = -1;
			case (func)
			FUNC_LOOKUP: begin
				n_lookup++;
				for (int i = 0; i < ENTRIES; i++)
					if (pick < 0 && ent_valid[i] && ent_ip[i] == ip)
						pick = i;
				if (pick >= 0) begin
					ent_stamp[pick] = now_sec;
					r.hit  = 1'b1;
					r.mac  = ent_mac[pick];
					r.slot = SLOT_W'(pick);
					n_hit++;
				end
			end
			FUNC_INSERT: begin
				n_insert++;
				for (int i = 0; i < ENTRIES; i++)
					if (pick < 0 && !ent_valid[i])
						pick = i;
				if (pick < 0) begin
					pick = int'(now_sec % STAMP_W'(ENTRIES));
					n_evict++;
				end
				ent_valid[pick] = 1'b1;
				ent_stamp[pick] = now_sec;
				ent_ip[pick]    = ip;
				ent_mac[pick]   = mac;
				r.slot = SLOT_W'(pick);
			end
			FUNC_TICK: begin
				n_tick++;
				now_sec = now_sec + 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					age = now_sec - ent_stamp[i];
					if (ent_valid[i] && age > STAMP_W'(max_age)) begin
						ent_valid[i] = 1'b0;
						n_expired++;
					end
				end
			end
			default: n_unused++;
			endcase
			replies.push_back(r);
		endfunction

		function void check_reply(arp_reply_t got);
			arp_reply_t want;
			if (replies.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected response: hit %0b mac %012h slot %0d",
						got.hit, got.mac, got.slot);
				return;
			end
			want = replies.pop_front();
			n_checked++;
			if (got.hit !== want.hit || got.mac !== want.mac || got.slot !== want.slot) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$write("response %0d: expected hit %0b mac %012h slot %0d, ",
						n_checked, want.hit, want.mac, want.slot);
					$display("got hit %0b mac %012h slot %0d",
						got.hit, got.mac, got.slot);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	arpc_in_if  req_ch ();
	arpc_out_if rsp_ch ();

	arp_cache_table_with_aging #(
		.TABLE_ENTRIES(ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	arp_table_scoreboard sb = new();

	bit              tx_burst;
	bit              rx_burst;
	int              words_sent;
	int              cfg_writes;
	int              stuck_cycles;
	int              pool_n;
	logic [IP_W-1:0] ip_pool [POOL_MAX];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, sb.replies.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		return {16'($urandom), $urandom};
	endfunction

	task automatic send_word(input logic [FUNC_W-1:0] func, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, TX_MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.func     <= func;
		req_ch.ip_addr  <= ip;
		req_ch.mac_addr <= mac;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(func, ip, mac);
		words_sent++;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.max_age = value;
		cfg_writes++;
	endtask

	task automatic run_directed();
		tx_burst = 1'b0;
		send_word(FUNC_LOOKUP, '0, '0);
		send_word(FUNC_INSERT, '0, '0);
		send_word(FUNC_INSERT, '1, '1);
		send_word(FUNC_INSERT, '1, 48'h0123_4567_89ab);
		// duplicate address: lowest slot wins
		send_word(FUNC_LOOKUP, '1, '1);
		send_word(FUNC_LOOKUP, '0, '1);
		send_word(FUNC_LOOKUP, 32'h8000_0000, '0);
		send_word(FUNC_UNUSED, '1, '1);
		send_word(FUNC_TICK, '1, '1);
		send_word(FUNC_LOOKUP, '1, '0);
		write_timeout('0);
		send_word(FUNC_LOOKUP, '0, '0);
		send_word(FUNC_TICK, '0, '0);
		send_word(FUNC_LOOKUP, '0, '0);
		send_word(FUNC_INSERT, 32'hc0a8_0001, 48'hffff_0000_ffff);
		send_word(FUNC_LOOKUP, 32'hc0a8_0001, '0);
	endtask

	task automatic run_phase(input int idx);
		logic [TIMEOUT_W-1:0] limit;
		logic [IP_W-1:0]      ip;
		int len, tick_pct, ins_pct, r;
		case (idx)
		0:       limit = '1;
		1:       limit = '0;
		2:       limit = 8'd1;
		default: begin
			if (idx % 7 == 6)
				limit = '1;
			else if ($urandom_range(0, 1) == 0)
				limit = TIMEOUT_W'($urandom_range(0, 24));
			else
				limit = TIMEOUT_W'($urandom_range(0, 255));
		end
		endcase
		write_timeout(limit);

		pool_n = (idx == 0) ? POOL_MAX : $urandom_range(4, POOL_MAX);
		for (int i = 0; i < POOL_MAX; i++)
			ip_pool[i] = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			ip_pool[0] = '0;
			ip_pool[1] = '1;
		end
		tx_burst = ($urandom_range(0, 3) == 0);
		tick_pct = (idx == 0) ? 5 : $urandom_range(2, 25);
		ins_pct  = (idx == 0) ? 60 : $urandom_range(20, 60);
		len      = $urandom_range(60, 160);

		for (int k = 0; k < len; k++) begin
			r  = $urandom_range(0, 99);
			ip = ($urandom_range(0, 9) != 0) ? ip_pool[$urandom_range(0, pool_n - 1)]
				: $urandom;
			if (r < 2)
				send_word(FUNC_UNUSED, $urandom, rand_mac());
			else if (r < 2 + tick_pct)
				send_word(FUNC_TICK, $urandom, rand_mac());
			else if (r < 2 + tick_pct + ins_pct)
				send_word(FUNC_INSERT, ip, rand_mac());
			else
				send_word(FUNC_LOOKUP, ip, rand_mac());
		end
	endtask

	initial begin : responder
		int         stall;
		arp_reply_t got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, RX_MAX_STALL);
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got.hit  = rsp_ch.hit;
			got.mac  = rsp_ch.mac_out;
			got.slot = rsp_ch.slot;
			sb.check_reply(got);
		end
	end

	initial begin : stimulus
		int phase;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= TIMEOUT_RST;
		req_ch.valid    <= 1'b0;
		req_ch.func     <= FUNC_LOOKUP;
		req_ch.ip_addr  <= '0;
		req_ch.mac_addr <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		phase = 0;
		while (words_sent < TARGET_WORDS) begin
			run_phase(phase);
			phase++;
		end
		wait_idle();

		$write("sent %0d words: %0d lookups (%0d hits), %0d inserts (%0d evictions), ",
			words_sent, sb.n_lookup, sb.n_hit, sb.n_insert, sb.n_evict);
		$display("%0d ticks (%0d expiries), %0d unused codes",
			sb.n_tick, sb.n_expired, sb.n_unused);
		$display("%0d timeout writes over %0d phases, %0d responses checked, %0d mismatches",
			cfg_writes, phase, sb.n_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
